// ===== hw/rtl/emr_pkg.sv =====
// Shared types, widths and microcode encoding for the midpoint ellipse rasterizer.
// Used by the ROM, sequencer, datapath, top level and checker; depends on nothing.
package emr_pkg;

  // Field and datapath widths.
  localparam int AXIS_W     = 5;               // semi-axis port width
  localparam int AXIS_BITS  = 5;               // semi-axis bits used
  localparam int CTR_W      = 10;              // center port width
  localparam int COORD_BITS = 11;              // output coordinate width
  localparam int OFS_W      = AXIS_BITS + 1;   // x, y offsets and point count
  localparam int SQ_W       = 2 * AXIS_BITS;   // a*a, b*b
  localparam int MUL_W      = 16;              // multiplier operand width
  localparam int D_W        = 2 * MUL_W;       // products and decision value
  localparam int CALC_W     = 17;              // coordinate adder width
  localparam int MAX_POINTS = 2 * (1 << AXIS_BITS) - 1;
  localparam int UPC_W      = 5;

  typedef logic [UPC_W-1:0] upc_t;

  // Microprogram addresses.
  localparam upc_t UA_S0  = 5'd0;
  localparam upc_t UA_S1  = 5'd1;
  localparam upc_t UA_S2  = 5'd2;
  localparam upc_t UA_L0  = 5'd3;
  localparam upc_t UA_L1  = 5'd4;
  localparam upc_t UA_L2  = 5'd5;
  localparam upc_t UA_I0  = 5'd6;
  localparam upc_t UA_I1  = 5'd7;
  localparam upc_t UA_W0  = 5'd8;
  localparam upc_t UA_W1  = 5'd9;
  localparam upc_t UA_W2  = 5'd10;
  localparam upc_t UA_W3  = 5'd11;
  localparam upc_t UA_W4  = 5'd12;
  localparam upc_t UA_W5  = 5'd13;
  localparam upc_t UA_U1A = 5'd14;
  localparam upc_t UA_U1B = 5'd15;
  localparam upc_t UA_U1C = 5'd16;
  localparam upc_t UA_U2A = 5'd17;
  localparam upc_t UA_U2B = 5'd18;
  localparam upc_t UA_U2C = 5'd19;

  // Multiplier left operand.
  typedef enum logic [2:0] {
    MA_A, MA_B, MA_AA, MA_BB, MA_P, MA_X21, MA_YM1
  } ma_sel_t;

  // Multiplier right operand: X21 = 2x+1, X22 = 2x+2, X23 = 2x+3, YM1 = y-1,
  // Y21 = 2y-1, B14 = 1-4b, Y22 = 2-2y, Y32 = 3-2y.
  typedef enum logic [3:0] {
    MB_A, MB_B, MB_AA, MB_BB, MB_X21, MB_X22, MB_X23, MB_YM1,
    MB_Y21, MB_B14, MB_Y22, MB_Y32
  } mb_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD, ACC_LOAD, ACC_INIT, ACC_ADD4, ACC_SUB4
  } acc_op_t;

  typedef enum logic [2:0] {
    SEQ_NEXT, SEQ_GOTO, SEQ_IF_S, SEQ_IF_NS, SEQ_EMIT, SEQ_ROUTE, SEQ_HALT
  } seq_op_t;

  typedef struct packed {
    logic    mul_en;
    ma_sel_t mul_a;
    mb_sel_t mul_b;
    acc_op_t acc;
    logic    ld_aa;
    logic    ld_bb;
    logic    ld_t;
    logic    ld_s;
    logic    inc_x;
    logic    dec_y;
    logic    set_r2;
    seq_op_t seq;
    upc_t    target;
  } uword_t;

  // Sequencer to datapath.
  typedef struct packed {
    uword_t uw;
    logic   step_en;
    logic   start;
    logic   emit_fire;
  } ctl_t;

  // Datapath to sequencer.
  typedef struct packed {
    logic cmp;
    logic more;
    logic s;
    logic c;
    logic r2;
    logic first;
    logic out_free;
  } stat_t;

endpackage

// ===== hw/rtl/emr_ucode_rom.sv =====
// Microprogram ROM of the ellipse rasterizer: one control word per step.
// Depends on emr_pkg for the control word layout and addresses.
module emr_ucode_rom (
  input  emr_pkg::upc_t   upc,
  output emr_pkg::uword_t uw
);

  always_comb begin
    uw = '0;
    unique case (upc)
      // Setup: square both semi-axes.
      emr_pkg::UA_S0: begin
        uw.mul_en = 1'b1; uw.mul_a = emr_pkg::MA_A; uw.mul_b = emr_pkg::MB_A;
      end
      emr_pkg::UA_S1: begin
        uw.ld_aa = 1'b1;
        uw.mul_en = 1'b1; uw.mul_a = emr_pkg::MA_B; uw.mul_b = emr_pkg::MB_B;
      end
      emr_pkg::UA_S2: begin
        uw.ld_bb = 1'b1;
      end
      // Per point: region test terms, then emit.
      emr_pkg::UA_L0: begin
        uw.mul_en = 1'b1; uw.mul_a = emr_pkg::MA_AA; uw.mul_b = emr_pkg::MB_Y21;
      end
      emr_pkg::UA_L1: begin
        uw.ld_t = 1'b1;
        uw.mul_en = 1'b1; uw.mul_a = emr_pkg::MA_BB; uw.mul_b = emr_pkg::MB_X22;
      end
      emr_pkg::UA_L2: begin
        uw.seq = emr_pkg::SEQ_EMIT;
      end
      // Initial region one decision value.
      emr_pkg::UA_I0: begin
        uw.mul_en = 1'b1; uw.mul_a = emr_pkg::MA_AA; uw.mul_b = emr_pkg::MB_B14;
      end
      emr_pkg::UA_I1: begin
        uw.acc = emr_pkg::ACC_INIT; uw.seq = emr_pkg::SEQ_ROUTE;
      end
      // Region two entry: bb(2x+1)^2 + 4aa(y-1)^2 - 4aa*bb.
      emr_pkg::UA_W0: begin
        uw.mul_en = 1'b1; uw.mul_a = emr_pkg::MA_X21; uw.mul_b = emr_pkg::MB_X21;
      end
      emr_pkg::UA_W1: begin
        uw.mul_en = 1'b1; uw.mul_a = emr_pkg::MA_P; uw.mul_b = emr_pkg::MB_BB;
      end
      emr_pkg::UA_W2: begin
        uw.acc = emr_pkg::ACC_LOAD;
        uw.mul_en = 1'b1; uw.mul_a = emr_pkg::MA_YM1; uw.mul_b = emr_pkg::MB_YM1;
      end
      emr_pkg::UA_W3: begin
        uw.mul_en = 1'b1; uw.mul_a = emr_pkg::MA_P; uw.mul_b = emr_pkg::MB_AA;
      end
      emr_pkg::UA_W4: begin
        uw.acc = emr_pkg::ACC_ADD4;
        uw.mul_en = 1'b1; uw.mul_a = emr_pkg::MA_AA; uw.mul_b = emr_pkg::MB_BB;
      end
      emr_pkg::UA_W5: begin
        uw.acc = emr_pkg::ACC_SUB4; uw.set_r2 = 1'b1;
        uw.seq = emr_pkg::SEQ_GOTO; uw.target = emr_pkg::UA_U2A;
      end
      // Region one step: east on a negative decision, else southeast.
      emr_pkg::UA_U1A: begin
        uw.ld_s = 1'b1;
        uw.mul_en = 1'b1; uw.mul_a = emr_pkg::MA_BB; uw.mul_b = emr_pkg::MB_X23;
      end
      emr_pkg::UA_U1B: begin
        uw.acc = emr_pkg::ACC_ADD4; uw.inc_x = 1'b1;
        uw.mul_en = 1'b1; uw.mul_a = emr_pkg::MA_AA; uw.mul_b = emr_pkg::MB_Y22;
        uw.seq = emr_pkg::SEQ_IF_S; uw.target = emr_pkg::UA_L0;
      end
      emr_pkg::UA_U1C: begin
        uw.acc = emr_pkg::ACC_ADD4; uw.dec_y = 1'b1;
        uw.seq = emr_pkg::SEQ_GOTO; uw.target = emr_pkg::UA_L0;
      end
      // Region two step: southeast on a negative decision, else south.
      emr_pkg::UA_U2A: begin
        uw.ld_s = 1'b1;
        uw.mul_en = 1'b1; uw.mul_a = emr_pkg::MA_AA; uw.mul_b = emr_pkg::MB_Y32;
      end
      emr_pkg::UA_U2B: begin
        uw.acc = emr_pkg::ACC_ADD4; uw.dec_y = 1'b1;
        uw.mul_en = 1'b1; uw.mul_a = emr_pkg::MA_BB; uw.mul_b = emr_pkg::MB_X22;
        uw.seq = emr_pkg::SEQ_IF_NS; uw.target = emr_pkg::UA_L0;
      end
      emr_pkg::UA_U2C: begin
        uw.acc = emr_pkg::ACC_ADD4; uw.inc_x = 1'b1;
        uw.seq = emr_pkg::SEQ_GOTO; uw.target = emr_pkg::UA_L0;
      end
      default: begin
        uw.seq = emr_pkg::SEQ_HALT;
      end
    endcase
  end

endmodule

// ===== hw/rtl/emr_sequencer.sv =====
// Step counter and branch logic of the ellipse rasterizer microsequencer.
// Depends on emr_pkg and emr_ucode_rom.
module emr_sequencer (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  emr_pkg::stat_t st,
  output emr_pkg::ctl_t  ctl
);

  emr_pkg::upc_t   upc_r, upc_nxt;
  logic            busy_r, busy_nxt;
  emr_pkg::uword_t uw;
  emr_pkg::upc_t   route_emit, route_later;
  logic            is_emit;

  emr_ucode_rom u_rom (
    .upc (upc_r),
    .uw  (uw)
  );

  // Picks the step routine for the next point from the region flags.
  function automatic emr_pkg::upc_t route(input logic r2, input logic c);
    emr_pkg::upc_t dst;
    if (r2) begin
      dst = emr_pkg::UA_U2A;
    end else if (!c) begin
      dst = emr_pkg::UA_W0;
    end else begin
      dst = emr_pkg::UA_U1A;
    end
    return dst;
  endfunction

  assign is_emit     = (uw.seq == emr_pkg::SEQ_EMIT);
  assign route_emit  = route(st.r2, st.cmp);
  assign route_later = route(st.r2, st.c);

  assign in_stall      = busy_r;
  assign ctl.uw        = uw;
  assign ctl.start     = in_valid && !busy_r;
  assign ctl.step_en   = busy_r && (!is_emit || st.out_free);
  assign ctl.emit_fire = busy_r && is_emit && st.out_free;

  always_comb begin
    upc_nxt  = upc_r;
    busy_nxt = busy_r;
    if (ctl.start) begin
      upc_nxt  = emr_pkg::UA_S0;
      busy_nxt = 1'b1;
    end else if (ctl.step_en) begin
      unique case (uw.seq)
        emr_pkg::SEQ_NEXT:  upc_nxt = emr_pkg::upc_t'(upc_r + 1'b1);
        emr_pkg::SEQ_GOTO:  upc_nxt = uw.target;
        emr_pkg::SEQ_IF_S:
          upc_nxt = st.s ? uw.target : emr_pkg::upc_t'(upc_r + 1'b1);
        emr_pkg::SEQ_IF_NS:
          upc_nxt = st.s ? emr_pkg::upc_t'(upc_r + 1'b1) : uw.target;
        emr_pkg::SEQ_EMIT: begin
          if (!st.more) begin
            busy_nxt = 1'b0;
          end else if (st.first) begin
            upc_nxt = emr_pkg::UA_I0;
          end else begin
            upc_nxt = route_emit;
          end
        end
        emr_pkg::SEQ_ROUTE: upc_nxt = route_later;
        default:            busy_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r  <= emr_pkg::UA_S0;
      busy_r <= 1'b0;
    end else begin
      upc_r  <= upc_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

// ===== hw/rtl/emr_datapath.sv =====
// Datapath of the ellipse rasterizer: operand muxes, one shared multiplier,
// decision accumulator, offsets and the output register. Depends on emr_pkg.
module emr_datapath (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  emr_pkg::ctl_t                          ctl,
  output emr_pkg::stat_t                         st,
  input  logic [emr_pkg::AXIS_W-1:0]             in_semi_axis_x,
  input  logic [emr_pkg::AXIS_W-1:0]             in_semi_axis_y,
  input  logic signed [emr_pkg::CTR_W-1:0]       in_origin_x,
  input  logic signed [emr_pkg::CTR_W-1:0]       in_origin_y,
  input  logic                                   out_stall,
  output logic                                   out_valid,
  output logic signed [emr_pkg::COORD_BITS-1:0]  out_right_x,
  output logic signed [emr_pkg::COORD_BITS-1:0]  out_left_x,
  output logic signed [emr_pkg::COORD_BITS-1:0]  out_upper_y,
  output logic signed [emr_pkg::COORD_BITS-1:0]  out_lower_y,
  output logic                                   out_last_point
);

  logic [emr_pkg::AXIS_BITS-1:0]        a_r, b_r;
  logic signed [emr_pkg::CTR_W-1:0]     cx_r, cy_r;
  logic [emr_pkg::SQ_W-1:0]             aa_r, bb_r;
  logic [emr_pkg::OFS_W-1:0]            x_r, y_r, n_r;
  logic signed [emr_pkg::D_W-1:0]       p_r, t_r, d_r;
  logic                                 s_r, c_r, r2_r, first_r, out_valid_r;

  logic signed [emr_pkg::MUL_W-1:0]     a16, b16, aa16, bb16, x16, y16, p16;
  logic signed [emr_pkg::MUL_W-1:0]     ma_v, mb_v;
  logic signed [emr_pkg::D_W-1:0]       prod, bb4, p4;
  logic signed [emr_pkg::CALC_W-1:0]    cx_w, cy_w, x_w, y_w;
  logic signed [emr_pkg::CALC_W-1:0]    rx_w, lx_w, uy_w, ly_w;
  logic                                 cmp, more;

  assign a16  = emr_pkg::MUL_W'(a_r);
  assign b16  = emr_pkg::MUL_W'(b_r);
  assign aa16 = emr_pkg::MUL_W'(aa_r);
  assign bb16 = emr_pkg::MUL_W'(bb_r);
  assign x16  = emr_pkg::MUL_W'(x_r);
  assign y16  = emr_pkg::MUL_W'(y_r);
  assign p16  = p_r[emr_pkg::MUL_W-1:0];

  always_comb begin
    unique case (ctl.uw.mul_a)
      emr_pkg::MA_A:   ma_v = a16;
      emr_pkg::MA_B:   ma_v = b16;
      emr_pkg::MA_AA:  ma_v = aa16;
      emr_pkg::MA_BB:  ma_v = bb16;
      emr_pkg::MA_P:   ma_v = p16;
      emr_pkg::MA_X21: ma_v = (x16 <<< 1) + 16'sd1;
      emr_pkg::MA_YM1: ma_v = y16 - 16'sd1;
      default:         ma_v = '0;
    endcase
  end

  always_comb begin
    unique case (ctl.uw.mul_b)
      emr_pkg::MB_A:   mb_v = a16;
      emr_pkg::MB_B:   mb_v = b16;
      emr_pkg::MB_AA:  mb_v = aa16;
      emr_pkg::MB_BB:  mb_v = bb16;
      emr_pkg::MB_X21: mb_v = (x16 <<< 1) + 16'sd1;
      emr_pkg::MB_X22: mb_v = (x16 <<< 1) + 16'sd2;
      emr_pkg::MB_X23: mb_v = (x16 <<< 1) + 16'sd3;
      emr_pkg::MB_YM1: mb_v = y16 - 16'sd1;
      emr_pkg::MB_Y21: mb_v = (y16 <<< 1) - 16'sd1;
      emr_pkg::MB_B14: mb_v = 16'sd1 - (b16 <<< 2);
      emr_pkg::MB_Y22: mb_v = 16'sd2 - (y16 <<< 1);
      emr_pkg::MB_Y32: mb_v = 16'sd3 - (y16 <<< 1);
      default:         mb_v = '0;
    endcase
  end

  assign prod = ma_v * mb_v;
  assign bb4  = emr_pkg::D_W'(bb_r) <<< 2;
  assign p4   = p_r <<< 2;

  // Region one goes on while aa(2y-1) > bb(2x+2); the run ends at y = 0 or
  // at the point count cap.
  assign cmp  = (t_r > p_r);
  assign more = ((!r2_r && cmp) || (y_r != '0)) &&
                (n_r != emr_pkg::OFS_W'(emr_pkg::MAX_POINTS - 1));

  assign st.cmp      = cmp;
  assign st.more     = more;
  assign st.s        = s_r;
  assign st.c        = c_r;
  assign st.r2       = r2_r;
  assign st.first    = first_r;
  assign st.out_free = !out_valid_r || !out_stall;

  assign cx_w = emr_pkg::CALC_W'(cx_r);
  assign cy_w = emr_pkg::CALC_W'(cy_r);
  assign x_w  = emr_pkg::CALC_W'(x_r);
  assign y_w  = emr_pkg::CALC_W'(y_r);
  assign rx_w = cx_w + x_w;
  assign lx_w = cx_w - x_w;
  assign uy_w = cy_w + y_w;
  assign ly_w = cy_w - y_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r         <= '0;
      r2_r        <= 1'b0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.start) begin
        n_r     <= '0;
        r2_r    <= 1'b0;
        first_r <= 1'b1;
      end else begin
        if (ctl.step_en && ctl.uw.set_r2) begin
          r2_r <= 1'b1;
        end
        if (ctl.emit_fire) begin
          n_r     <= emr_pkg::OFS_W'(n_r + 1'b1);
          first_r <= 1'b0;
        end
      end
      if (ctl.emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a_r  <= in_semi_axis_x[emr_pkg::AXIS_BITS-1:0];
      b_r  <= in_semi_axis_y[emr_pkg::AXIS_BITS-1:0];
      cx_r <= in_origin_x;
      cy_r <= in_origin_y;
      x_r  <= '0;
      y_r  <= emr_pkg::OFS_W'(in_semi_axis_y[emr_pkg::AXIS_BITS-1:0]);
    end else if (ctl.step_en) begin
      if (ctl.uw.mul_en) p_r  <= prod;
      if (ctl.uw.ld_aa)  aa_r <= p_r[emr_pkg::SQ_W-1:0];
      if (ctl.uw.ld_bb)  bb_r <= p_r[emr_pkg::SQ_W-1:0];
      if (ctl.uw.ld_t)   t_r  <= p_r;
      if (ctl.uw.ld_s)   s_r  <= d_r[emr_pkg::D_W-1];
      if (ctl.uw.inc_x)  x_r  <= emr_pkg::OFS_W'(x_r + 1'b1);
      if (ctl.uw.dec_y)  y_r  <= emr_pkg::OFS_W'(y_r - 1'b1);
      case (ctl.uw.acc)
        emr_pkg::ACC_LOAD: d_r <= p_r;
        emr_pkg::ACC_INIT: d_r <= p_r + bb4;
        emr_pkg::ACC_ADD4: d_r <= d_r + p4;
        emr_pkg::ACC_SUB4: d_r <= d_r - p4;
        default:           d_r <= d_r;
      endcase
    end
    if (ctl.emit_fire) begin
      c_r            <= cmp;
      out_right_x    <= rx_w[emr_pkg::COORD_BITS-1:0];
      out_left_x     <= lx_w[emr_pkg::COORD_BITS-1:0];
      out_upper_y    <= uy_w[emr_pkg::COORD_BITS-1:0];
      out_lower_y    <= ly_w[emr_pkg::COORD_BITS-1:0];
      out_last_point <= !more;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/midpoint_ellipse_rasterizer_core.sv =====
// Top level of the midpoint ellipse rasterizer: microsequencer plus datapath.
// Depends on emr_pkg, emr_sequencer and emr_datapath.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_stall    semi_axis_x, semi_axis_y, origin_x, origin_y
//   out      output     out_valid/out_stall  right_x, left_x, upper_y, lower_y, last_point
//
// One ellipse request gives up to 63 points. Setup squares both semi-axes; each point
// then runs the region test and emit steps and a step routine, plus the initial decision
// value after the first point and the entry routine on entry to region two, since one
// shared multiplier serves a single microcode step per cycle while the output is free.
// Reset is synchronous and leaves the block idle.
// A stalled output holds the microprogram at its emit step.
module midpoint_ellipse_rasterizer_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [emr_pkg::AXIS_W-1:0]             in_semi_axis_x,
  input  logic [emr_pkg::AXIS_W-1:0]             in_semi_axis_y,
  input  logic signed [emr_pkg::CTR_W-1:0]       in_origin_x,
  input  logic signed [emr_pkg::CTR_W-1:0]       in_origin_y,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [emr_pkg::COORD_BITS-1:0]  out_right_x,
  output logic signed [emr_pkg::COORD_BITS-1:0]  out_left_x,
  output logic signed [emr_pkg::COORD_BITS-1:0]  out_upper_y,
  output logic signed [emr_pkg::COORD_BITS-1:0]  out_lower_y,
  output logic                                   out_last_point
);

  emr_pkg::ctl_t  ctl;
  emr_pkg::stat_t st;

  emr_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .ctl      (ctl)
  );

  emr_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .st             (st),
    .in_semi_axis_x (in_semi_axis_x),
    .in_semi_axis_y (in_semi_axis_y),
    .in_origin_x    (in_origin_x),
    .in_origin_y    (in_origin_y),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_right_x    (out_right_x),
    .out_left_x     (out_left_x),
    .out_upper_y    (out_upper_y),
    .out_lower_y    (out_lower_y),
    .out_last_point (out_last_point)
  );

endmodule

// ===== hw/rtl/emr_checker.sv =====
// Port-level checks for the midpoint ellipse rasterizer, bound to the top level.
// Depends on emr_pkg and midpoint_ellipse_rasterizer_core.
module emr_checker (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   in_valid,
  input logic                                   in_stall,
  input logic                                   out_valid,
  input logic                                   out_stall,
  input logic signed [emr_pkg::COORD_BITS-1:0]  out_right_x,
  input logic signed [emr_pkg::COORD_BITS-1:0]  out_left_x,
  input logic signed [emr_pkg::COORD_BITS-1:0]  out_upper_y,
  input logic signed [emr_pkg::COORD_BITS-1:0]  out_lower_y,
  input logic                                   out_last_point
);

  // An accepted request keeps the input side closed while it runs.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after an accepted item");

  // The input opens again only once the final point has been loaded.
  a_open_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_stall) |-> (out_valid && out_last_point))
    else $error("input reopened without a final point on the output");

  // Mirrored coordinates differ by twice the offset, so their parity matches.
  a_mirror_parity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_right_x[0] == out_left_x[0]) &&
                   (out_upper_y[0] == out_lower_y[0])))
    else $error("mirrored coordinates are inconsistent");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_right_x) &&
      $stable(out_left_x) && $stable(out_upper_y) && $stable(out_lower_y) &&
      $stable(out_last_point)))
    else $error("stalled output item changed");

endmodule

bind midpoint_ellipse_rasterizer_core emr_checker u_emr_checker (.*);

// ===== test/tb.sv =====
// Testbench for midpoint_ellipse_rasterizer_core: sends ellipse requests and checks every
// emitted point against a behavioral predictor of the midpoint walk. Depends on emr_pkg.
module tb;

  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES    = 60;

  typedef struct packed {
    logic signed [emr_pkg::COORD_BITS-1:0] right_x;
    logic signed [emr_pkg::COORD_BITS-1:0] left_x;
    logic signed [emr_pkg::COORD_BITS-1:0] upper_y;
    logic signed [emr_pkg::COORD_BITS-1:0] lower_y;
    logic                                  last_point;
  } point_t;

  logic                                  clk = 1'b0;
  logic                                  rst_n = 1'b0;
  logic                                  in_valid = 1'b0;
  logic                                  in_stall;
  logic [emr_pkg::AXIS_W-1:0]            in_semi_axis_x = '0;
  logic [emr_pkg::AXIS_W-1:0]            in_semi_axis_y = '0;
  logic signed [emr_pkg::CTR_W-1:0]      in_origin_x = '0;
  logic signed [emr_pkg::CTR_W-1:0]      in_origin_y = '0;
  logic                                  out_valid;
  logic                                  out_stall = 1'b0;
  logic signed [emr_pkg::COORD_BITS-1:0] out_right_x;
  logic signed [emr_pkg::COORD_BITS-1:0] out_left_x;
  logic signed [emr_pkg::COORD_BITS-1:0] out_upper_y;
  logic signed [emr_pkg::COORD_BITS-1:0] out_lower_y;
  logic                                  out_last_point;

  point_t pending_points[$];
  int     mismatch_count = 0;
  int     sender_idle_pct = 0;
  int     receiver_stall_pct = 0;
  int     hold_requests = 0;
  int     hold_served = 0;
  int     hold_left = 0;
  int     quiet_cycles = 0;

  midpoint_ellipse_rasterizer_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_semi_axis_x (in_semi_axis_x),
    .in_semi_axis_y (in_semi_axis_y),
    .in_origin_x    (in_origin_x),
    .in_origin_y    (in_origin_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_right_x    (out_right_x),
    .out_left_x     (out_left_x),
    .out_upper_y    (out_upper_y),
    .out_lower_y    (out_lower_y),
    .out_last_point (out_last_point)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Walks the first quadrant from (0, b) and queues every point the block should emit.
  // Decision values are kept scaled by four so that all terms stay integer.
  function automatic void rasterize_quadrant(input int a, input int b, input int cx,
                                             input int cy);
    longint aa, bb, x, y, d;
    bit     region_two, above_split, more;
    int     n;
    point_t pt;
    aa = a * a;
    bb = b * b;
    x = 0;
    y = b;
    d = 0;
    region_two = 1'b0;
    n = 0;
    forever begin
      above_split = (2 * aa * y - aa > 2 * bb * (x + 1));
      more = (!region_two && above_split) ? 1'b1 : (y > 0);
      if (n + 1 >= emr_pkg::MAX_POINTS) more = 1'b0;
      pt.right_x    = emr_pkg::COORD_BITS'(cx + x);
      pt.left_x     = emr_pkg::COORD_BITS'(cx - x);
      pt.upper_y    = emr_pkg::COORD_BITS'(cy + y);
      pt.lower_y    = emr_pkg::COORD_BITS'(cy - y);
      pt.last_point = !more;
      pending_points.push_back(pt);
      n++;
      if (!more) break;
      if (n == 1) d = 4 * bb - 4 * aa * b + aa;
      if (!region_two && !above_split) begin
        region_two = 1'b1;
        d = bb * (2 * x + 1) * (2 * x + 1) + 4 * aa * (y - 1) * (y - 1) - 4 * aa * bb;
      end
      if (!region_two) begin
        if (d < 0) begin
          d += 4 * bb * (2 * x + 3);
        end else begin
          d += 4 * bb * (2 * x + 3) + 4 * aa * (2 - 2 * y);
          y--;
        end
        x++;
      end else begin
        if (d < 0) begin
          d += 4 * bb * (2 * x + 2) + 4 * aa * (3 - 2 * y);
          x++;
        end else begin
          d += 4 * aa * (3 - 2 * y);
        end
        y--;
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch on %s at %0t: got %0d, expected %0d", what, $time, got, want);
    mismatch_count++;
  endtask

  // Offers one request and holds it until the block takes it.
  task automatic send_ellipse(input logic [emr_pkg::AXIS_W-1:0] a,
                              input logic [emr_pkg::AXIS_W-1:0] b,
                              input logic signed [emr_pkg::CTR_W-1:0] cx,
                              input logic signed [emr_pkg::CTR_W-1:0] cy);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_semi_axis_x <= a;
    in_semi_axis_y <= b;
    in_origin_x    <= cx;
    in_origin_y    <= cy;
    do @(posedge clk); while (in_stall);
    rasterize_quadrant(a, b, cx, cy);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_points.size() != 0);
  endtask

  task automatic send_random_ellipse();
    logic [emr_pkg::AXIS_W-1:0] a, b;
    a = emr_pkg::AXIS_W'($urandom_range(31));
    b = emr_pkg::AXIS_W'($urandom_range(31));
    // Lean on the largest and degenerate axes now and then.
    if ($urandom_range(7) == 0) a = $urandom_range(1) ? 5'd31 : 5'd0;
    if ($urandom_range(7) == 0) b = $urandom_range(1) ? 5'd31 : 5'd0;
    send_ellipse(a, b, emr_pkg::CTR_W'($urandom_range(1023)),
                 emr_pkg::CTR_W'($urandom_range(1023)));
  endtask

  task automatic test_directed();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    send_ellipse(5'd0, 5'd0, 10'sd0, 10'sd0);
    send_ellipse(5'd0, 5'd31, 10'sd3, -10'sd7);
    send_ellipse(5'd31, 5'd0, -10'sd9, 10'sd4);
    send_ellipse(5'd0, 5'd1, 10'sd0, 10'sd0);
    send_ellipse(5'd1, 5'd0, 10'sd0, 10'sd0);
    send_ellipse(5'd1, 5'd1, 10'sd1, -10'sd1);
    send_ellipse(5'd31, 5'd31, -10'sd512, -10'sd512);
    send_ellipse(5'd31, 5'd31, 10'sd511, 10'sd511);
    send_ellipse(5'd31, 5'd31, 10'sd511, -10'sd512);
    send_ellipse(5'd31, 5'd30, -10'sd512, 10'sd511);
    send_ellipse(5'd30, 5'd31, 10'sd100, 10'sd200);
    send_ellipse(5'd31, 5'd1, 10'sd0, 10'sd0);
    send_ellipse(5'd1, 5'd31, 10'sd0, 10'sd0);
    send_ellipse(5'd2, 5'd3, -10'sd1, -10'sd1);
    send_ellipse(5'd3, 5'd2, 10'sd5, 10'sd5);
    send_ellipse(5'd16, 5'd8, -10'sd300, 10'sd300);
    send_ellipse(5'd8, 5'd16, 10'sd300, -10'sd300);
    send_ellipse(5'd21, 5'd10, 10'sd0, 10'sd0);
    wait_for_drain();
  endtask

  task automatic test_random(input int idle_pct, input int stall_pct, input int count);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (count) send_random_ellipse();
    wait_for_drain();
  endtask

  // The output is held off long enough that the block fills and stalls its input.
  task automatic test_backpressure();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_requests++;
    repeat (6) send_random_ellipse();
    wait_for_drain();
  endtask

  always @(posedge clk) begin
    if (hold_left == 0 && hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    point_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_points.size() == 0) begin
        report_mismatch("unexpected point right_x", out_right_x, 0);
      end else begin
        want = pending_points.pop_front();
        if (out_right_x !== want.right_x) report_mismatch("right_x", out_right_x, want.right_x);
        if (out_left_x !== want.left_x) report_mismatch("left_x", out_left_x, want.left_x);
        if (out_upper_y !== want.upper_y) report_mismatch("upper_y", out_upper_y, want.upper_y);
        if (out_lower_y !== want.lower_y) report_mismatch("lower_y", out_lower_y, want.lower_y);
        if (out_last_point !== want.last_point)
          report_mismatch("last_point", out_last_point, want.last_point);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(22, 79, 50);
    test_random(79, 22, 50);
    test_random(0, 0, 40);
    test_backpressure();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_points.size() != 0)
      report_mismatch("points still outstanding", pending_points.size(), 0);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/emr_pkg.sv
hw/rtl/emr_ucode_rom.sv
hw/rtl/emr_sequencer.sv
hw/rtl/emr_datapath.sv
hw/rtl/midpoint_ellipse_rasterizer_core.sv
hw/rtl/emr_checker.sv
test/tb.sv
